@@ design/i2cms_pkg.sv @@
// Shared types and codes for the I2C master transaction sequencer.
// No dependencies; imported by every module of the block.
package i2cms_pkg;

  // Input operation codes
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_STEP  = 2'd1;
  localparam logic [1:0] OP_INIT  = 2'd2;

  // Sequencer phases
  localparam logic [1:0] PH_START   = 2'd0;
  localparam logic [1:0] PH_ADDRESS = 2'd1;
  localparam logic [1:0] PH_DATA    = 2'd2;
  localparam logic [1:0] PH_STOP    = 2'd3;

  // Byte engine commands
  localparam logic [1:0] CMD_NONE  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_STOP  = 2'd2;
  localparam logic [1:0] CMD_XFER  = 2'd3;

  // Byte sent while reading, and the read/write bit of the address byte
  localparam logic [7:0] READ_FILL_BYTE = 8'hFF;
  localparam logic [7:0] ADDR_READ_BIT  = 8'h01;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] target_address;
    logic [7:0] byte_count;
    logic       is_write;
    logic       want_stop;
    logic       engine_busy;
    logic       engine_ack;
    logic [7:0] engine_rx_byte;
    logic [7:0] next_write_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0] engine_cmd;
    logic [7:0] tx_byte;
    logic       master_ack;
    logic       write_byte_taken;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       busy_res;
    logic       done_res;
    logic       failed;
  } out_item_t;

endpackage

@@ design/i2c_master_transaction_sequencer.sv @@
// I2C master transaction sequencer: one result beat per input beat.
// Throughput: one beat per cycle while out_stall is low; input register, one
// step of sequencing logic, result register. While a result waits the input
// register takes one more beat. Reset (rst_n low, synchronous): both stages
// empty, sequencer idle in start phase with all status flags clear. Depends on
// i2cms_pkg and i2cms_step.
module i2c_master_transaction_sequencer import i2cms_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic      in_valid_r;
  in_item_t  in_data_r;
  logic      out_valid_r;
  out_item_t out_data_r;
  out_item_t step_res;
  logic      out_load;
  logic      step_en;

  // The result register takes a beat when empty or being drained
  assign out_load = !out_valid_r || !out_stall;
  assign step_en  = in_valid_r && out_load;
  assign in_stall = in_valid_r && !out_load;

  // Hold the accepted input beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_data_r <= in_data;
    end
  end

  i2cms_step u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .item    (in_data_r),
    .res     (step_res)
  );

  // Hold the result beat until the receiver takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_data_r <= step_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ design/i2cms_step.sv @@
// Transaction state registers and the per-beat sequencing decision.
// Depends on i2cms_pkg for item types, phase and command codes.
module i2cms_step import i2cms_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step_en,
  input  in_item_t  item,
  output out_item_t res
);

  logic [1:0] phase_r, phase_nxt;
  logic [7:0] held_address_r, held_address_nxt;
  logic [7:0] remaining_r, remaining_nxt;
  logic       dir_write_r, dir_write_nxt;
  logic       stop_wanted_r, stop_wanted_nxt;
  logic       first_read_r, first_read_nxt;
  logic       busy_flag_r, busy_flag_nxt;
  logic       done_flag_r, done_flag_nxt;
  logic       failed_flag_r, failed_flag_nxt;

  // Decide the engine command and the next state for one beat
  always_comb begin
    phase_nxt        = phase_r;
    held_address_nxt = held_address_r;
    remaining_nxt    = remaining_r;
    dir_write_nxt    = dir_write_r;
    stop_wanted_nxt  = stop_wanted_r;
    first_read_nxt   = first_read_r;
    busy_flag_nxt    = busy_flag_r;
    done_flag_nxt    = done_flag_r;
    failed_flag_nxt  = failed_flag_r;
    res              = '0;

    if (item.op == OP_START) begin
      phase_nxt        = PH_START;
      held_address_nxt = item.target_address;
      remaining_nxt    = item.byte_count;
      dir_write_nxt    = item.is_write;
      stop_wanted_nxt  = item.want_stop;
      first_read_nxt   = 1'b0;
      busy_flag_nxt    = 1'b1;
      done_flag_nxt    = 1'b0;
      failed_flag_nxt  = 1'b0;
    end else if (item.op == OP_INIT) begin
      res.engine_cmd  = CMD_STOP;
      busy_flag_nxt   = 1'b0;
      done_flag_nxt   = 1'b0;
      failed_flag_nxt = 1'b0;
    end else if (item.op == OP_STEP && busy_flag_r && !item.engine_busy) begin
      case (phase_r)
        PH_START: begin
          res.engine_cmd = CMD_START;
          phase_nxt      = PH_ADDRESS;
        end
        PH_ADDRESS: begin
          res.engine_cmd = CMD_XFER;
          res.tx_byte    = dir_write_r ? held_address_r : (held_address_r | ADDR_READ_BIT);
          phase_nxt      = PH_DATA;
        end
        PH_DATA: begin
          if (dir_write_r) begin
            if (!item.engine_ack) failed_flag_nxt = 1'b1;
            res.engine_cmd       = CMD_XFER;
            res.tx_byte          = item.next_write_byte;
            res.write_byte_taken = 1'b1;
            if (remaining_r == 8'd1) begin
              if (stop_wanted_r) begin
                phase_nxt = PH_STOP;
              end else begin
                busy_flag_nxt = 1'b0;
                done_flag_nxt = 1'b1;
              end
            end
          end else begin
            // return the byte fetched by the previous read transfer
            if (first_read_r) begin
              res.rx_valid = 1'b1;
              res.rx_byte  = item.engine_rx_byte;
            end
            if (remaining_r != 8'd0) begin
              res.engine_cmd = CMD_XFER;
              res.tx_byte    = READ_FILL_BYTE;
              res.master_ack = (remaining_r > 8'd1);
              first_read_nxt = 1'b1;
            end else begin
              phase_nxt = PH_STOP;
            end
          end
          // wraps modulo 256
          remaining_nxt = remaining_r - 8'd1;
        end
        default: begin
          if (dir_write_r && !item.engine_ack) failed_flag_nxt = 1'b1;
          res.engine_cmd = CMD_STOP;
          busy_flag_nxt  = 1'b0;
          done_flag_nxt  = 1'b1;
        end
      endcase
    end

    res.busy_res = busy_flag_nxt;
    res.done_res = done_flag_nxt;
    res.failed   = failed_flag_nxt;
  end

  // Commit state when the beat moves into the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_START;
      held_address_r <= '0;
      remaining_r    <= '0;
      dir_write_r    <= 1'b0;
      stop_wanted_r  <= 1'b0;
      first_read_r   <= 1'b0;
      busy_flag_r    <= 1'b0;
      done_flag_r    <= 1'b0;
      failed_flag_r  <= 1'b0;
    end else if (step_en) begin
      phase_r        <= phase_nxt;
      held_address_r <= held_address_nxt;
      remaining_r    <= remaining_nxt;
      dir_write_r    <= dir_write_nxt;
      stop_wanted_r  <= stop_wanted_nxt;
      first_read_r   <= first_read_nxt;
      busy_flag_r    <= busy_flag_nxt;
      done_flag_r    <= done_flag_nxt;
      failed_flag_r  <= failed_flag_nxt;
    end
  end

  // Busy and done are never reported together
  a_busy_done_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(busy_flag_r && done_flag_r))
    else $error("busy and done set together");

  // A failure is only ever flagged during a write transaction
  a_fail_on_write: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(failed_flag_r) |-> $past(dir_write_r))
    else $error("failed flag rose outside a write");

  // An issued start condition is followed by the address phase
  a_start_to_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && res.engine_cmd == CMD_START) |=> (phase_r == PH_ADDRESS))
    else $error("start condition not followed by address phase");

  // Received bytes are only returned on reads
  a_rx_on_read: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && res.rx_valid) |-> !dir_write_r)
    else $error("received byte returned during a write");

endmodule
